// File: rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: epoch seconds to calendar shared definitions
// Sequencer states, calendar constants and the month length lookup.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int SecondsWidth = 32;
   localparam int DaysWidth    = 16;
   localparam int SubWidth     = 17;
   localparam int RemWidth     = 6;
   localparam int ProdWidth    = 64;

   localparam logic [11:0] EPOCH_YEAR = 12'd1970;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
   localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
   localparam logic [5:0]  DAYS_PER_WEEK = 6'd7;
   localparam logic [15:0] WEEKDAY_OFFSET = 16'd4;

   localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
   localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

   // Epoch year position inside the 4, 100 and 400 year cycles
   localparam logic [1:0] EPOCH_MOD4   = 2'd2;
   localparam logic [6:0] EPOCH_MOD100 = 7'd70;
   localparam logic [8:0] EPOCH_MOD400 = 9'd370;
   localparam logic [6:0] LAST_MOD100  = 7'd99;
   localparam logic [8:0] LAST_MOD400  = 9'd399;

   localparam logic [3:0] MONTH_JAN = 4'd0;
   localparam logic [3:0] MONTH_FEB = 4'd1;
   localparam logic [3:0] MONTH_DEC = 4'd11;

   // Reciprocals and shifts that give exact quotients over the operand ranges
   localparam logic [31:0] RECIP_60 = 32'h8888_8889;
   localparam int          SHIFT_60 = 37;
   localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
   localparam int          SHIFT_24 = 36;
   localparam logic [31:0] RECIP_7  = 32'h9249_2493;
   localparam int          SHIFT_7  = 34;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_SEC,
      ST_REM_SEC,
      ST_DIV_MIN,
      ST_REM_MIN,
      ST_DIV_HOUR,
      ST_REM_HOUR,
      ST_DIV_WDAY,
      ST_REM_WDAY,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } esc_state_type;

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd0:    len = 5'd31;
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/core/esc_ifs.sv
// ----------------------------------------------------------------------------
// esc_ifs: request and response channels
// Valid/ready channels carrying the epoch count in and the calendar fields out.
// ----------------------------------------------------------------------------
interface esc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] unix_seconds;

   modport source (output valid, output unix_seconds, input ready);
   modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface esc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [2:0]  weekday;

   modport source (output valid, output year, output month, output day, output hour,
                   output minute, output second, output weekday, input ready);
   modport sink   (input valid, input year, input month, input day, input hour,
                   input minute, input second, input weekday, output ready);
endinterface

// File: rtl/core/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: Unix seconds to Gregorian date and time
// Converts a 32-bit UTC epoch count into year, month, day, hour, minute,
// second and weekday (Sunday is 1) with a shared multiplier and subtractor.
// ----------------------------------------------------------------------------
// One request is converted at a time; req_chan.ready is low while it runs.
// Each division by 60, 60, 24 and 7 takes a reciprocal multiply for the
// quotient, then a multiply back and subtract for the remainder. The year
// walk then steps once per whole year from 1970 (up to 136 years), the
// month walk once per whole month (up to 11 months), and a closing state
// loads the response; late December 2105 makes the longest walk. ready
// returns together with that load, so a new request can be taken once the
// response is loaded. A single 32x32 multiplier and a 17-bit compare-and-
// subtract unit do all the work, and the year walk takes the longest. The
// response sits in its own register, so a new request can be taken while
// the previous response still waits for rsp_chan.ready; a second finished
// conversion then holds, with ready low, until that response is taken.
module epoch_seconds_to_calendar
   import esc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   esc_req_if.sink       req_chan,
   esc_rsp_if.source     rsp_chan
);

   esc_state_type state_ff, state_in;

   logic [SecondsWidth-1:0] work_ff, work_in;
   logic [SecondsWidth-1:0] quot_ff, quot_in;
   logic [DaysWidth-1:0]    days_ff, days_in;
   logic [11:0]             year_ff, year_in;
   logic [3:0]              mon_ff, mon_in;
   logic [5:0]              sec_ff, sec_in;
   logic [5:0]              min_ff, min_in;
   logic [4:0]              hour_ff, hour_in;
   logic [2:0]              wday_ff, wday_in;
   logic [1:0]              y4_ff, y4_in;
   logic [6:0]              y100_ff, y100_in;
   logic [8:0]              y400_ff, y400_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_year_ff, rsp_year_in;
   logic [3:0]  rsp_month_ff, rsp_month_in;
   logic [4:0]  rsp_day_ff, rsp_day_in;
   logic [4:0]  rsp_hour_ff, rsp_hour_in;
   logic [5:0]  rsp_minute_ff, rsp_minute_in;
   logic [5:0]  rsp_second_ff, rsp_second_in;
   logic [2:0]  rsp_weekday_ff, rsp_weekday_in;

   logic [SubWidth-1:0]     sub_a, sub_b;
   logic [SubWidth:0]       sub_diff;
   logic                    sub_ge;
   logic [SecondsWidth-1:0] mul_a, mul_b;
   logic [ProdWidth-1:0]    mul_prod;
   logic                    leap;
   logic [8:0]              year_len;
   logic [DaysWidth-1:0]    wday_dividend;

   assign leap     = (y4_ff == 2'd0) && ((y100_ff != 7'd0) || (y400_ff == 9'd0));
   assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;

   always_comb begin
      sub_a = '0;
      sub_b = '0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DIV_SEC: begin
            mul_a = work_ff;
            mul_b = RECIP_60;
         end
         ST_DIV_MIN: begin
            mul_a = work_ff;
            mul_b = RECIP_60;
         end
         ST_DIV_HOUR: begin
            mul_a = work_ff;
            mul_b = RECIP_24;
         end
         ST_DIV_WDAY: begin
            mul_a = work_ff;
            mul_b = RECIP_7;
         end
         ST_REM_SEC: begin
            mul_a = quot_ff;
            mul_b = {{(SecondsWidth-6){1'b0}}, SECS_PER_MIN};
            sub_a = {{(SubWidth-RemWidth){1'b0}}, work_ff[RemWidth-1:0]};
            sub_b = {{(SubWidth-RemWidth){1'b0}}, mul_prod[RemWidth-1:0]};
         end
         ST_REM_MIN: begin
            mul_a = quot_ff;
            mul_b = {{(SecondsWidth-6){1'b0}}, MINS_PER_HOUR};
            sub_a = {{(SubWidth-RemWidth){1'b0}}, work_ff[RemWidth-1:0]};
            sub_b = {{(SubWidth-RemWidth){1'b0}}, mul_prod[RemWidth-1:0]};
         end
         ST_REM_HOUR: begin
            mul_a = quot_ff;
            mul_b = {{(SecondsWidth-6){1'b0}}, HOURS_PER_DAY};
            sub_a = {{(SubWidth-RemWidth){1'b0}}, work_ff[RemWidth-1:0]};
            sub_b = {{(SubWidth-RemWidth){1'b0}}, mul_prod[RemWidth-1:0]};
         end
         ST_REM_WDAY: begin
            mul_a = quot_ff;
            mul_b = {{(SecondsWidth-6){1'b0}}, DAYS_PER_WEEK};
            sub_a = {{(SubWidth-RemWidth){1'b0}}, work_ff[RemWidth-1:0]};
            sub_b = {{(SubWidth-RemWidth){1'b0}}, mul_prod[RemWidth-1:0]};
         end
         ST_YEAR: begin
            sub_a = {1'b0, days_ff};
            sub_b = {{(SubWidth-9){1'b0}}, year_len};
         end
         ST_MONTH: begin
            sub_a = {1'b0, days_ff};
            sub_b = {{(SubWidth-5){1'b0}}, month_days(mon_ff, leap)};
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = ProdWidth'(mul_a) * ProdWidth'(mul_b);
   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !sub_diff[SubWidth];

   assign wday_dividend = quot_ff[DaysWidth-1:0] + WEEKDAY_OFFSET;

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      quot_in  = quot_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      mon_in   = mon_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      wday_in  = wday_ff;
      y4_in    = y4_ff;
      y100_in  = y100_ff;
      y400_in  = y400_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_year_in    = rsp_year_ff;
      rsp_month_in   = rsp_month_ff;
      rsp_day_in     = rsp_day_ff;
      rsp_hour_in    = rsp_hour_ff;
      rsp_minute_in  = rsp_minute_ff;
      rsp_second_in  = rsp_second_ff;
      rsp_weekday_in = rsp_weekday_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               work_in  = req_chan.unix_seconds;
               state_in = ST_DIV_SEC;
            end
         end
         ST_DIV_SEC: begin
            quot_in  = SecondsWidth'(mul_prod >> SHIFT_60);
            state_in = ST_REM_SEC;
         end
         ST_REM_SEC: begin
            sec_in   = sub_diff[RemWidth-1:0];
            work_in  = quot_ff;
            state_in = ST_DIV_MIN;
         end
         ST_DIV_MIN: begin
            quot_in  = SecondsWidth'(mul_prod >> SHIFT_60);
            state_in = ST_REM_MIN;
         end
         ST_REM_MIN: begin
            min_in   = sub_diff[RemWidth-1:0];
            work_in  = quot_ff;
            state_in = ST_DIV_HOUR;
         end
         ST_DIV_HOUR: begin
            quot_in  = SecondsWidth'(mul_prod >> SHIFT_24);
            state_in = ST_REM_HOUR;
         end
         ST_REM_HOUR: begin
            hour_in  = sub_diff[4:0];
            days_in  = quot_ff[DaysWidth-1:0];
            work_in  = {{(SecondsWidth-DaysWidth){1'b0}}, wday_dividend};
            state_in = ST_DIV_WDAY;
         end
         ST_DIV_WDAY: begin
            quot_in  = SecondsWidth'(mul_prod >> SHIFT_7);
            state_in = ST_REM_WDAY;
         end
         ST_REM_WDAY: begin
            wday_in  = sub_diff[2:0] + 3'd1;
            year_in  = EPOCH_YEAR;
            y4_in    = EPOCH_MOD4;
            y100_in  = EPOCH_MOD100;
            y400_in  = EPOCH_MOD400;
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            if (sub_ge) begin
               days_in = sub_diff[DaysWidth-1:0];
               year_in = year_ff + 12'd1;
               y4_in   = y4_ff + 2'd1;
               y100_in = (y100_ff == LAST_MOD100) ? 7'd0 : y100_ff + 7'd1;
               y400_in = (y400_ff == LAST_MOD400) ? 9'd0 : y400_ff + 9'd1;
            end else begin
               mon_in   = MONTH_JAN;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (sub_ge && (mon_ff != MONTH_DEC)) begin
               days_in = sub_diff[DaysWidth-1:0];
               mon_in  = mon_ff + 4'd1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_year_in    = year_ff;
               rsp_month_in   = mon_ff + 4'd1;
               rsp_day_in     = days_ff[4:0] + 5'd1;
               rsp_hour_in    = hour_ff;
               rsp_minute_in  = min_ff;
               rsp_second_in  = sec_ff;
               rsp_weekday_in = wday_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff        <= work_in;
      quot_ff        <= quot_in;
      days_ff        <= days_in;
      year_ff        <= year_in;
      mon_ff         <= mon_in;
      sec_ff         <= sec_in;
      min_ff         <= min_in;
      hour_ff        <= hour_in;
      wday_ff        <= wday_in;
      y4_ff          <= y4_in;
      y100_ff        <= y100_in;
      y400_ff        <= y400_in;
      rsp_year_ff    <= rsp_year_in;
      rsp_month_ff   <= rsp_month_in;
      rsp_day_ff     <= rsp_day_in;
      rsp_hour_ff    <= rsp_hour_in;
      rsp_minute_ff  <= rsp_minute_in;
      rsp_second_ff  <= rsp_second_in;
      rsp_weekday_ff <= rsp_weekday_in;
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.year    = rsp_year_ff;
   assign rsp_chan.month   = rsp_month_ff;
   assign rsp_chan.day     = rsp_day_ff;
   assign rsp_chan.hour    = rsp_hour_ff;
   assign rsp_chan.minute  = rsp_minute_ff;
   assign rsp_chan.second  = rsp_second_ff;
   assign rsp_chan.weekday = rsp_weekday_ff;

endmodule

// File: rtl/core/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker: port-level checks for the epoch to calendar converter
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module esc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second,
   input logic [2:0]  rsp_weekday
);

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("converter still ready right after taking a request");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_year >= 12'd1970) && (rsp_year <= 12'd2106)
                 && (rsp_month >= 4'd1) && (rsp_month <= 4'd12)
                 && (rsp_day >= 5'd1) && (rsp_day <= 5'd31)
                 && (rsp_weekday >= 3'd1) && (rsp_weekday <= 3'd7))
      else $error("date field out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59))
      else $error("time field out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_year) && $stable(rsp_month)
         && $stable(rsp_day) && $stable(rsp_hour) && $stable(rsp_minute)
         && $stable(rsp_second) && $stable(rsp_weekday))
      else $error("stalled response dropped or changed");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_year    (rsp_chan.year),
   .rsp_month   (rsp_chan.month),
   .rsp_day     (rsp_chan.day),
   .rsp_hour    (rsp_chan.hour),
   .rsp_minute  (rsp_chan.minute),
   .rsp_second  (rsp_chan.second),
   .rsp_weekday (rsp_chan.weekday)
);

// File: test/epoch_seconds_to_calendar_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb: self-checking bench for the epoch converter
// Sends epoch counts over the request channel and checks every response
// against a calendar computed in the bench. Covers range extremes, day and
// year boundaries, century leap years and random counts, with idle sender,
// stalling receiver and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;
   import esc_pkg::*;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } calendar_type;

   typedef struct {
      logic [31:0]  secs;
      calendar_type date;
   } pending_date_type;

   localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned DRAIN_CYCLES   = 300;
   localparam int unsigned HOLDOFF_CYCLES = 800;

   logic clock;
   logic reset;

   esc_req_if req_chan ();
   esc_rsp_if rsp_chan ();

   pending_date_type expected_dates [$];
   int unsigned      mismatches;
   int unsigned      send_idle_pct;
   int unsigned      rsp_stall_pct;
   bit               holdoff_req;

   epoch_seconds_to_calendar DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #15_000_000;
      $display("** epoch_seconds_to_calendar: FAILED **");
      $finish;
   end

   function automatic bit is_leap(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic calendar_type compute_calendar(input logic [31:0] secs);
      calendar_type cal;
      int unsigned  rest;
      int unsigned  yr;
      int unsigned  mo;
      int unsigned  mlen;
      rest = secs;
      cal.second = 6'(rest % 60);
      rest = rest / 60;
      cal.minute = 6'(rest % 60);
      rest = rest / 60;
      cal.hour = 5'(rest % 24);
      rest = rest / 24;
      cal.weekday = 3'((rest + 4) % 7 + 1);
      yr = 1970;
      while (rest >= (is_leap(yr) ? 366 : 365)) begin
         rest = rest - (is_leap(yr) ? 366 : 365);
         yr++;
      end
      mo = 0;
      mlen = MONTH_LEN[0];
      while (mo < 11 && rest >= mlen) begin
         rest = rest - mlen;
         mo++;
         mlen = (mo == 1 && is_leap(yr)) ? 29 : MONTH_LEN[mo];
      end
      cal.year  = 12'(yr);
      cal.month = 4'(mo + 1);
      cal.day   = 5'(rest + 1);
      return cal;
   endfunction

   function automatic logic [31:0] random_epoch();
      int unsigned pick;
      logic [31:0] val;
      pick = $urandom_range(99);
      if (pick < 55) begin
         val = $urandom;
      end else if (pick < 75) begin
         val = $urandom_range(49710) * 86400;
         if ($urandom_range(1)) val = val - 32'd1;
      end else if (pick < 85) begin
         val = $urandom_range(2_000_000);
      end else begin
         val = 32'hFFFF_FFFF - $urandom_range(40_000_000);
      end
      return val;
   endfunction

   task automatic send_request(input logic [31:0] secs);
      pending_date_type entry;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.unix_seconds <= secs;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      entry.secs = secs;
      entry.date = compute_calendar(secs);
      expected_dates.push_back(entry);
      @(negedge clock);
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) send_request(random_epoch());
   endtask

   task automatic check_field(input string name, input logic [31:0] secs,
                              input int unsigned exp, input int unsigned act);
      if (exp != act) begin
         $display("%0t: %s mismatch for %0d: expected %0d, actual %0d",
                  $time, name, secs, exp, act);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      pending_date_type entry;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %0d-%0d-%0d",
                     $time, rsp_chan.year, rsp_chan.month, rsp_chan.day);
            mismatches++;
         end else begin
            entry = expected_dates.pop_front();
            check_field("year",    entry.secs, entry.date.year,    rsp_chan.year);
            check_field("month",   entry.secs, entry.date.month,   rsp_chan.month);
            check_field("day",     entry.secs, entry.date.day,     rsp_chan.day);
            check_field("hour",    entry.secs, entry.date.hour,    rsp_chan.hour);
            check_field("minute",  entry.secs, entry.date.minute,  rsp_chan.minute);
            check_field("second",  entry.secs, entry.date.second,  rsp_chan.second);
            check_field("weekday", entry.secs, entry.date.weekday, rsp_chan.weekday);
         end
      end
   end

   initial begin
      int unsigned holdoff_left;
      holdoff_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req  = 1'b0;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic test_directed();
      logic [31:0] corners [$];
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      corners = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
                  32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
                  32'd68169600, 32'd94694399, 32'd951782400, 32'd951868800,
                  32'd978307199, 32'd4107542399, 32'd4107542400,
                  32'd2147483647, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hFFFF_FFFE, 32'd4294944000};
      foreach (corners[i]) send_request(corners[i]);
   endtask

   task automatic test_streaming();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random(260);
   endtask

   task automatic test_sender_idle();
      send_idle_pct = 85;
      rsp_stall_pct = 0;
      run_random(200);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;
      rsp_stall_pct = 85;
      run_random(200);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 14;
      rsp_stall_pct = 14;
      run_random(260);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_req   = 1'b1;
      run_random(10);
   endtask

   initial begin
      mismatches            = 0;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;
      holdoff_req           = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.unix_seconds = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_streaming();
      test_sender_idle();
      test_receiver_stall();
      test_backpressure();
      test_both_idle();

      req_chan.valid <= 1'b0;
      rsp_stall_pct = 0;
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** epoch_seconds_to_calendar: PASSED **");
      end else begin
         $display("** epoch_seconds_to_calendar: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/esc_pkg.sv
rtl/core/esc_ifs.sv
rtl/core/epoch_seconds_to_calendar.sv
rtl/core/esc_checker.sv
test/epoch_seconds_to_calendar_tb.sv
